// ===== rtl/core/fes_pkg.sv =====
`timescale 1ns / 1ps

package fes_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 2 * (VAL_W + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_MUL,
        ST_CMP,
        ST_SWAP,
        ST_FETCH,
        ST_EMIT
    } fes_state_t;

    typedef enum logic [1:0] {
        WR_ITEM,
        WR_FROM_A,
        WR_FROM_B
    } fes_wr_sel_t;

    // order of the codes follows the order of the values
    typedef enum logic [1:0] {
        CLS_UNORD,
        CLS_NEG_INF,
        CLS_FINITE,
        CLS_POS_INF
    } fes_cls_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        fes_wr_sel_t      wr_sel;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr_a;
        logic [IDX_W-1:0] rd_addr_b;
        logic             cmp_en;
        logic             cnt_inc;
        logic             cnt_clr;
    } fes_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
        logic             greater;
    } fes_stat_t;

    function automatic fes_cls_t frac_class(input logic [VAL_W-1:0] n,
                                            input logic [VAL_W-1:0] d);
        fes_cls_t c;
        if (d != '0)
            c = CLS_FINITE;
        else if (n == '0)
            c = CLS_UNORD;
        else if (n[VAL_W-1])
            c = CLS_NEG_INF;
        else
            c = CLS_POS_INF;
        return c;
    endfunction

endpackage

// ===== rtl/core/fes_if.sv =====
`timescale 1ns / 1ps

interface fes_item_if;
    logic                          valid;
    logic                          ready;
    logic signed [fes_pkg::VAL_W-1:0] numerator;
    logic signed [fes_pkg::VAL_W-1:0] denominator;
    logic                          final_item;

    modport source (output valid, output numerator, output denominator,
                    output final_item, input ready);
    modport sink   (input valid, input numerator, input denominator,
                    input final_item, output ready);
endinterface

interface fes_result_if;
    logic                          valid;
    logic                          ready;
    logic signed [fes_pkg::VAL_W-1:0] sorted_numerator;
    logic signed [fes_pkg::VAL_W-1:0] sorted_denominator;
    logic                          end_of_set;

    modport source (output valid, output sorted_numerator, output sorted_denominator,
                    output end_of_set, input ready);
    modport sink   (input valid, input sorted_numerator, input sorted_denominator,
                    input end_of_set, output ready);
endinterface

// ===== rtl/core/fes_datapath.sv =====
`timescale 1ns / 1ps

module fes_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fes_pkg::fes_cmd_t            cmd,
    input  logic [fes_pkg::VAL_W-1:0]    item_num,
    input  logic [fes_pkg::VAL_W-1:0]    item_den,
    output fes_pkg::fes_stat_t           stat,
    output logic [fes_pkg::VAL_W-1:0]    rd_num,
    output logic [fes_pkg::VAL_W-1:0]    rd_den
);

    logic [2*fes_pkg::VAL_W-1:0] mem [fes_pkg::ENTRIES];
    logic [2*fes_pkg::VAL_W-1:0] rd_a_reg;
    logic [2*fes_pkg::VAL_W-1:0] rd_b_reg;
    logic [2*fes_pkg::VAL_W-1:0] wr_data;
    logic [fes_pkg::CNT_W-1:0]   count_reg;
    logic [fes_pkg::CNT_W-1:0]   count_next;

    logic signed [fes_pkg::VAL_W:0]    na, da, nb, db;
    logic signed [fes_pkg::PROD_W-1:0] prod_a_reg, prod_b_reg;
    fes_pkg::fes_cls_t                 cls_a_reg, cls_b_reg;
    logic                              greater;

    always_comb
    begin
        case (cmd.wr_sel)
            fes_pkg::WR_ITEM:   wr_data = {item_den, item_num};
            fes_pkg::WR_FROM_A: wr_data = rd_a_reg;
            fes_pkg::WR_FROM_B: wr_data = rd_b_reg;
            default:            wr_data = {item_den, item_num};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_a_reg <= mem[cmd.rd_addr_a];
            rd_b_reg <= mem[cmd.rd_addr_b];
        end
    end

    // normalize signs so both denominators are non-negative
    always_comb
    begin
        na = rd_a_reg[fes_pkg::VAL_W-1] ? -$signed({rd_a_reg[fes_pkg::VAL_W-1],
                                                   rd_a_reg[fes_pkg::VAL_W-1:0]})
                                        :  $signed({rd_a_reg[fes_pkg::VAL_W-1],
                                                   rd_a_reg[fes_pkg::VAL_W-1:0]});
        da = $signed({rd_a_reg[2*fes_pkg::VAL_W-1], rd_a_reg[2*fes_pkg::VAL_W-1:fes_pkg::VAL_W]});
        nb = $signed({rd_b_reg[fes_pkg::VAL_W-1], rd_b_reg[fes_pkg::VAL_W-1:0]});
        db = $signed({rd_b_reg[2*fes_pkg::VAL_W-1], rd_b_reg[2*fes_pkg::VAL_W-1:fes_pkg::VAL_W]});
        if (rd_a_reg[2*fes_pkg::VAL_W-1])
        begin
            na = -$signed({rd_a_reg[fes_pkg::VAL_W-1], rd_a_reg[fes_pkg::VAL_W-1:0]});
            da = -da;
        end
        else
        begin
            na = $signed({rd_a_reg[fes_pkg::VAL_W-1], rd_a_reg[fes_pkg::VAL_W-1:0]});
        end
        if (rd_b_reg[2*fes_pkg::VAL_W-1])
        begin
            nb = -nb;
            db = -db;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmp_en)
        begin
            prod_a_reg <= na * db;
            prod_b_reg <= nb * da;
            cls_a_reg  <= fes_pkg::frac_class(rd_a_reg[fes_pkg::VAL_W-1:0],
                                              rd_a_reg[2*fes_pkg::VAL_W-1:fes_pkg::VAL_W]);
            cls_b_reg  <= fes_pkg::frac_class(rd_b_reg[fes_pkg::VAL_W-1:0],
                                              rd_b_reg[2*fes_pkg::VAL_W-1:fes_pkg::VAL_W]);
        end
    end

    always_comb
    begin
        if (cls_a_reg == fes_pkg::CLS_UNORD || cls_b_reg == fes_pkg::CLS_UNORD)
            greater = 1'b0;
        else if (cls_a_reg != cls_b_reg)
            greater = cls_a_reg > cls_b_reg;
        else if (cls_a_reg != fes_pkg::CLS_FINITE)
            greater = 1'b0;
        else
            greater = prod_a_reg > prod_b_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_clr)
            count_next = '0;
        else if (cmd.cnt_inc)
            count_next = count_reg + fes_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign stat.count   = count_reg;
    assign stat.full    = (count_reg == fes_pkg::CNT_W'(fes_pkg::ENTRIES));
    assign stat.greater = greater;
    assign rd_num       = rd_a_reg[fes_pkg::VAL_W-1:0];
    assign rd_den       = rd_a_reg[2*fes_pkg::VAL_W-1:fes_pkg::VAL_W];

endmodule

// ===== rtl/core/fes_ctrl.sv =====
`timescale 1ns / 1ps

module fes_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_final,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_last,
    input  fes_pkg::fes_stat_t stat,
    output fes_pkg::fes_cmd_t  cmd
);

    localparam int XW = fes_pkg::CNT_W + 1;

    fes_pkg::fes_state_t       state_reg, state_next;
    logic [fes_pkg::IDX_W-1:0] i_reg, i_next;
    logic [fes_pkg::IDX_W-1:0] j_reg, j_next;
    logic [fes_pkg::IDX_W-1:0] k_reg, k_next;
    logic [XW-1:0]             cnt_x, cnt_after, j_inc, i_inc2, k_inc;
    logic                      pair_next_j, pair_next_i;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fes_pkg::ST_LOAD;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        cnt_x       = XW'(stat.count);
        cnt_after   = stat.full ? cnt_x : cnt_x + XW'(1);
        j_inc       = XW'(j_reg) + XW'(1);
        i_inc2      = XW'(i_reg) + XW'(2);
        k_inc       = XW'(k_reg) + XW'(1);
        pair_next_j = j_inc < cnt_x;
        pair_next_i = i_inc2 < cnt_x;
    end

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        out_last      = (k_inc == cnt_x);
        cmd           = '0;
        cmd.wr_sel    = fes_pkg::WR_ITEM;
        cmd.wr_addr   = stat.count[fes_pkg::IDX_W-1:0];
        cmd.rd_addr_a = i_reg;
        cmd.rd_addr_b = j_reg;

        case (state_reg)
            fes_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.wr_en   = !stat.full;
                    cmd.cnt_inc = !stat.full;
                    if (in_final)
                    begin
                        i_next = '0;
                        j_next = fes_pkg::IDX_W'(1);
                        k_next = '0;
                        state_next = (cnt_after >= XW'(2)) ? fes_pkg::ST_READ
                                                           : fes_pkg::ST_FETCH;
                    end
                end
            end
            fes_pkg::ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = fes_pkg::ST_MUL;
            end
            fes_pkg::ST_MUL:
            begin
                cmd.cmp_en = 1'b1;
                state_next = fes_pkg::ST_CMP;
            end
            fes_pkg::ST_CMP, fes_pkg::ST_SWAP:
            begin
                if (state_reg == fes_pkg::ST_CMP && stat.greater)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = i_reg;
                    cmd.wr_sel  = fes_pkg::WR_FROM_B;
                    state_next  = fes_pkg::ST_SWAP;
                end
                else
                begin
                    if (state_reg == fes_pkg::ST_SWAP)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = j_reg;
                        cmd.wr_sel  = fes_pkg::WR_FROM_A;
                    end
                    // advance to the next pair
                    if (pair_next_j)
                    begin
                        j_next     = j_inc[fes_pkg::IDX_W-1:0];
                        state_next = fes_pkg::ST_READ;
                    end
                    else if (pair_next_i)
                    begin
                        i_next     = i_reg + fes_pkg::IDX_W'(1);
                        j_next     = i_inc2[fes_pkg::IDX_W-1:0];
                        state_next = fes_pkg::ST_READ;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = fes_pkg::ST_FETCH;
                    end
                end
            end
            fes_pkg::ST_FETCH:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_addr_a = k_reg;
                state_next    = fes_pkg::ST_EMIT;
            end
            fes_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (out_last)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = fes_pkg::ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_inc[fes_pkg::IDX_W-1:0];
                        state_next = fes_pkg::ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = fes_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// ===== rtl/core/fraction_exchange_sorter.sv =====
`timescale 1ns / 1ps
// Fraction exchange sorter.
// items (sink): one signed fraction per beat; final_item closes the set.
// results (source): the set in ascending order of value, one fraction per
// beat, end_of_set on the last beat of the run.
// While loading, every valid beat is taken; fractions beyond the store depth are
// dropped, but a dropped final beat still starts the run.
// After the final beat the sort visits every pair (i, j), i < j, n(n-1)/2
// pairs for n stored fractions: each pair passes the read, multiply and
// compare states, and a pair that swaps adds a swap state, since the
// fraction store has a single write port.
// Each output beat is a store read followed by the output beat itself.
// items.ready is high only while loading; no beat is taken during a run.
// A stall on results holds the current beat until it is taken.
// Reset empties the set and leaves the block ready to load; the store
// contents are not cleared.
module fraction_exchange_sorter (
    input  logic         clk,
    input  logic         rst_n,
    fes_item_if.sink     items,
    fes_result_if.source results
);

    fes_pkg::fes_cmd_t          cmd;
    fes_pkg::fes_stat_t         stat;
    logic [fes_pkg::VAL_W-1:0]  rd_num;
    logic [fes_pkg::VAL_W-1:0]  rd_den;
    logic                       out_last;

    fes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_final  (items.final_item),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_last  (out_last),
        .stat      (stat),
        .cmd       (cmd)
    );

    fes_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item_num (items.numerator),
        .item_den (items.denominator),
        .stat     (stat),
        .rd_num   (rd_num),
        .rd_den   (rd_den)
    );

    assign results.sorted_numerator   = $signed(rd_num);
    assign results.sorted_denominator = $signed(rd_den);
    assign results.end_of_set         = out_last;

    a_load_xor_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(items.ready && results.valid))
        else $error("load and output overlap");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= fes_pkg::CNT_W'(fes_pkg::ENTRIES))
        else $error("entry count above store depth");

    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.ready && results.end_of_set
        |=> items.ready && stat.count == '0)
        else $error("run end did not return to loading");

    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> stat.count != '0)
        else $error("output beat with empty set");

endmodule

// ===== sim/tb_fraction_exchange_sorter.sv =====
`timescale 1ns / 1ps

module tb_fraction_exchange_sorter;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 110;
    localparam int REPORT_MAX   = 10;

    typedef logic signed [fes_pkg::VAL_W-1:0] frac_word_t;

    typedef struct packed {
        frac_word_t num;
        frac_word_t den;
        logic       eos;
    } sorted_beat_t;

    class sort_scoreboard;
        frac_word_t   held_num [fes_pkg::ENTRIES];
        frac_word_t   held_den [fes_pkg::ENTRIES];
        int           held_count;
        sorted_beat_t pending [$];
        int           mismatches;
        int           sets_done;
        int           items_in;
        int           dropped;
        int           beats_out;

        function new();
            held_count = 0;
            mismatches = 0;
            sets_done  = 0;
            items_in   = 0;
            dropped    = 0;
            beats_out  = 0;
        endfunction

        function fes_pkg::fes_cls_t value_class(input frac_word_t n, input frac_word_t d);
            if (d != 0)
                return fes_pkg::CLS_FINITE;
            if (n > 0)
                return fes_pkg::CLS_POS_INF;
            if (n < 0)
                return fes_pkg::CLS_NEG_INF;
            return fes_pkg::CLS_UNORD;
        endfunction

        function bit is_greater(input frac_word_t a_n, input frac_word_t a_d,
                                input frac_word_t b_n, input frac_word_t b_d);
            fes_pkg::fes_cls_t ca;
            fes_pkg::fes_cls_t cb;
            longint   an;
            longint   ad;
            longint   bn;
            longint   bd;
            ca = value_class(a_n, a_d);
            cb = value_class(b_n, b_d);
            if (ca == fes_pkg::CLS_UNORD || cb == fes_pkg::CLS_UNORD)
                return 1'b0;
            if (ca != cb)
                return ca > cb;
            if (ca != fes_pkg::CLS_FINITE)
                return 1'b0;
            an = longint'(a_n);
            ad = longint'(a_d);
            bn = longint'(b_n);
            bd = longint'(b_d);
            if (ad < 0)
            begin
                an = -an;
                ad = -ad;
            end
            if (bd < 0)
            begin
                bn = -bn;
                bd = -bd;
            end
            return an * bd > bn * ad;
        endfunction

        function void note_item(input frac_word_t n, input frac_word_t d, input logic last);
            frac_word_t   tn;
            frac_word_t   td;
            sorted_beat_t b;
            items_in++;
            if (held_count < fes_pkg::ENTRIES)
            begin
                held_num[held_count] = n;
                held_den[held_count] = d;
                held_count++;
            end
            else
                dropped++;
            if (!last)
                return;
            for (int i = 0; i + 1 < held_count; i++)
                for (int j = i + 1; j < held_count; j++)
                    if (is_greater(held_num[i], held_den[i], held_num[j], held_den[j]))
                    begin
                        tn = held_num[i];
                        td = held_den[i];
                        held_num[i] = held_num[j];
                        held_den[i] = held_den[j];
                        held_num[j] = tn;
                        held_den[j] = td;
                    end
            for (int i = 0; i < held_count; i++)
            begin
                b.num = held_num[i];
                b.den = held_den[i];
                b.eos = (i == held_count - 1);
                pending.push_back(b);
            end
            held_count = 0;
            sets_done++;
        endfunction

        function void report(input string what, input sorted_beat_t want,
                             input sorted_beat_t got);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%s: expected %0d/%0d end %0b, got %0d/%0d end %0b", what,
                         want.num, want.den, want.eos, got.num, got.den, got.eos);
        endfunction

        function void check_result(input frac_word_t n, input frac_word_t d, input logic eos);
            sorted_beat_t got;
            sorted_beat_t want;
            got.num = n;
            got.den = d;
            got.eos = eos;
            beats_out++;
            if (pending.size() == 0)
            begin
                report("unexpected beat", '0, got);
                return;
            end
            want = pending.pop_front();
            if (want.num !== got.num || want.den !== got.den || want.eos !== got.eos)
                report("mismatch", want, got);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   sender_idle_pct = 0;
    int   result_stall_pct = 0;
    bit   hold_results = 1'b0;
    int   random_items = 0;

    sort_scoreboard sb = new();

    fes_item_if   items_if ();
    fes_result_if results_if ();

    fraction_exchange_sorter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[fraction_exchange_sorter] ERROR");
            $finish;
        end
    end

    initial
    begin
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results_if.ready <= rst_n && !hold_results &&
                                ($urandom_range(0, 99) >= result_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
            sb.check_result(results_if.sorted_numerator, results_if.sorted_denominator,
                            results_if.end_of_set);
    end

    task automatic send_fraction(input frac_word_t n, input frac_word_t d, input logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            items_if.valid <= 1'b0;
            @(negedge clk);
        end
        items_if.valid       <= 1'b1;
        items_if.numerator   <= n;
        items_if.denominator <= d;
        items_if.final_item  <= last;
        do
            @(posedge clk);
        while (!items_if.ready);
        sb.note_item(n, d, last);
    endtask

    function automatic void pick_fraction(output frac_word_t n, output frac_word_t d);
        frac_word_t edges [5] = '{-32768, -1, 0, 1, 32767};
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                n = frac_word_t'($urandom_range(0, 65535));
                d = frac_word_t'($urandom_range(0, 65535));
            end
            4, 5:
            begin
                n = frac_word_t'($signed($urandom_range(0, 8)) - 4);
                d = frac_word_t'($signed($urandom_range(0, 8)) - 4);
            end
            6:
            begin
                n = frac_word_t'(($signed($urandom_range(0, 2)) - 1) *
                                 $signed($urandom_range(1, 32767)));
                d = '0;
            end
            7:
            begin
                n = edges[$urandom_range(0, 4)];
                d = edges[$urandom_range(0, 4)];
            end
            default:
            begin
                n = frac_word_t'($signed($urandom_range(0, 200)) - 100);
                d = frac_word_t'($signed($urandom_range(1, 100)));
                if ($urandom_range(0, 1))
                    d = -d;
            end
        endcase
    endfunction

    task automatic send_random_set(input int len);
        frac_word_t n;
        frac_word_t d;
        for (int k = 0; k < len; k++)
        begin
            pick_fraction(n, d);
            send_fraction(n, d, k == len - 1);
        end
        random_items += len;
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int start;
        int len;
        sender_idle_pct  = idle_pct;
        result_stall_pct = stall_pct;
        start = random_items;
        while (random_items - start < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(fes_pkg::ENTRIES + 1, fes_pkg::ENTRIES + 4);
            else
                len = $urandom_range(1, fes_pkg::ENTRIES);
            send_random_set(len);
        end
    endtask

    task automatic run_directed();
        send_fraction(32767, 1, 1'b1);

        send_fraction(-32768, -32768, 1'b0);
        send_fraction(32767, -32768, 1'b0);
        send_fraction(-32768, 1, 1'b0);
        send_fraction(0, 5, 1'b0);
        send_fraction(5, 0, 1'b0);
        send_fraction(7, 0, 1'b0);
        send_fraction(-3, 0, 1'b0);
        send_fraction(0, 0, 1'b0);
        send_fraction(1, -1, 1'b1);

        send_fraction(0, 0, 1'b0);
        send_fraction(-32768, 0, 1'b0);
        send_fraction(1, 3, 1'b0);
        send_fraction(2, 6, 1'b0);
        send_fraction(-1, -3, 1'b0);
        send_fraction(32767, 32767, 1'b0);
        send_fraction(-1, 0, 1'b0);
        send_fraction(0, -1, 1'b1);

        send_fraction(3, -2, 1'b0);
        send_fraction(-1, 1, 1'b1);
    endtask

    initial
    begin
        rst_n                = 1'b0;
        items_if.valid       = 1'b0;
        items_if.numerator   = '0;
        items_if.denominator = '0;
        items_if.final_item  = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_phase(0, 0);

        // hold the output side while sets keep arriving
        sender_idle_pct  = 0;
        result_stall_pct = 0;
        fork
            begin
                @(posedge clk);
                hold_results = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            begin
                send_random_set(fes_pkg::ENTRIES);
                send_random_set(fes_pkg::ENTRIES);
                send_random_set(fes_pkg::ENTRIES + 2);
            end
        join

        run_phase(65, 0);
        run_phase(0, 65);
        run_phase(32, 32);

        @(negedge clk);
        items_if.valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending.size() != 0)
            $display("%0d sorted beats never arrived", sb.pending.size());
        $display("%0d sets sorted from %0d fractions, %0d dropped past the store depth",
                 sb.sets_done, sb.items_in, sb.dropped);
        $display("%0d beats checked across free flow, gaps, stalls and a %0d-cycle hold",
                 sb.beats_out, HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[fraction_exchange_sorter] OK");
        else
            $display("[fraction_exchange_sorter] ERROR");
        $finish;
    end

endmodule
